// File: sv/hwt_pkg.sv
// Shared widths, codes and constants of the hashed word table.
package hwt_pkg;

  localparam int HASH_W         = 32;
  localparam int VALUE_W        = 15;
  localparam int TABLE_SIZE_DEF = 1024;
  localparam int ROT_L          = 13;

  localparam logic [2:0] MAX_CHARS = 3'd5;

  localparam logic [VALUE_W-1:0] CANNED_DIV = 15'd1000;

  localparam logic [1:0] MODE_STORE  = 2'd0;
  localparam logic [1:0] MODE_USER   = 2'd1;
  localparam logic [1:0] MODE_CANNED = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [2:0] ST_STORED    = 3'd0;
  localparam logic [2:0] ST_FOUND     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_OVERFLOW  = 3'd3;
  localparam logic [2:0] ST_MISSING   = 3'd4;

endpackage

// File: sv/hashed_word_table_core.sv
// Hashed word table: byte-serial hashing and a linear-probing slot memory.
//
//  channel | dir | tdata (low bit first)                          | tuser       | tlast
//  in_     | in  | char_byte[7:0] word_type[12:8] store_value[27:13] | mode[1:0]   | last_char
//  out_    | out | found_value[14:0]                              | status[2:0] | -
//
// A byte that is not the last of its word is taken while the core stays in S_IDLE.
// A last byte goes through three steps of the reciprocal hash-modulo unit, then a memory
// read and a compare and write back for each probed slot P, then the output load;
// P reaches TABLE_SIZE when no slot answers. A last byte in MODE_UNUSED only clears the hash.
// After reset a clearing pass writes all TABLE_SIZE slots, one per cycle; no request
// is taken until it ends.
// A waiting result blocks neither bytes nor probes; only the next output load waits for it.
module hashed_word_table_core
  import hwt_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // char_byte, word_type, store_value, 4 unused bits
  input  logic [1:0]  in_tuser,   // mode
  input  logic        in_tlast,   // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // found_value, 1'b0
  output logic [2:0]  out_tuser   // status
);

  localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int MW = HASH_W + VALUE_W;
  localparam logic [AW:0] TS = (AW+1)'(TABLE_SIZE);
  localparam logic [HASH_W-1:0] TS_W = HASH_W'(TABLE_SIZE);
  localparam longint unsigned RECIP_WIDE = (64'd1 << HASH_W) / 64'(TABLE_SIZE);
  localparam logic [HASH_W-1:0] RECIP = HASH_W'(RECIP_WIDE);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_REM   = 3'd3;
  localparam logic [2:0] S_FIX   = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_EVAL  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]          state_r, state_nxt;
  logic [HASH_W-1:0]   acc_r, acc_nxt;
  logic [2:0]          chars_r, chars_nxt;
  logic [HASH_W-1:0]   hash_r, hash_nxt;
  logic [1:0]          mode_r, mode_nxt;
  logic [VALUE_W-1:0]  base_r, base_nxt;
  logic [VALUE_W-1:0]  val_r, val_nxt;
  logic [HASH_W-1:0]   quot_r, quot_nxt;
  logic [HASH_W-1:0]   rem_r, rem_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [AW:0]         probe_cnt_r, probe_cnt_nxt;
  logic [2:0]          res_status_r, res_status_nxt;
  logic [VALUE_W-1:0]  res_value_r, res_value_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [2:0]          out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;

  logic [MW-1:0]       mem [TABLE_SIZE];
  logic [MW-1:0]       rd_data_r;
  logic                mem_we;
  logic [MW-1:0]       mem_wd;

  logic [7:0]          in_char;
  logic [HASH_W-1:0]   h_add, h_fold, acc_upd;
  logic [2:0]          chars_upd;
  logic [2*HASH_W-1:0] recip_prod;
  logic [HASH_W-1:0]   quot_mul;
  logic [AW:0]         idx_inc, probe_inc;
  logic [VALUE_W-1:0]  rd_val, val_diff;
  logic [HASH_W-1:0]   rd_hash;
  logic                slot_empty, hash_hit, type_hit;

  assign in_char   = in_tdata[7:0];
  assign h_add     = acc_r + {24'd0, in_char};
  assign h_fold    = h_add - ((h_add << ROT_L) | (h_add >> (HASH_W - ROT_L)));

  always_comb begin
    acc_upd   = acc_r;
    chars_upd = chars_r;
    if (chars_r != 3'd0) begin
      if (in_char == 8'd0) begin
        chars_upd = 3'd0;
      end else begin
        if (!in_char[7]) begin
          chars_upd = chars_r - 3'd1;
        end
        acc_upd = h_fold;
      end
    end
  end

  assign recip_prod = (2*HASH_W)'(hash_r) * (2*HASH_W)'(RECIP);
  assign quot_mul   = quot_r * TS_W;
  assign idx_inc    = {1'b0, idx_r} + (AW+1)'(1);
  assign probe_inc  = probe_cnt_r + (AW+1)'(1);
  assign rd_val     = rd_data_r[VALUE_W-1:0];
  assign rd_hash    = rd_data_r[MW-1:VALUE_W];
  assign slot_empty = (rd_val == '0);
  assign hash_hit   = (rd_hash == hash_r);
  assign val_diff   = rd_val - base_r;
  assign type_hit   = (rd_val >= base_r) && (val_diff < CANNED_DIV);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_value_r};
  assign out_tuser  = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    acc_nxt        = acc_r;
    chars_nxt      = chars_r;
    hash_nxt       = hash_r;
    mode_nxt       = mode_r;
    base_nxt       = base_r;
    val_nxt        = val_r;
    quot_nxt       = quot_r;
    rem_nxt        = rem_r;
    idx_nxt        = idx_r;
    probe_cnt_nxt  = probe_cnt_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    mem_we         = 1'b0;
    mem_wd         = {hash_r, val_r};

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wd = '0;
        if (idx_inc == TS) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_inc[AW-1:0];
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tlast) begin
            acc_nxt   = '0;
            chars_nxt = MAX_CHARS;
            if (in_tuser != MODE_UNUSED) begin
              hash_nxt  = acc_upd;
              mode_nxt  = in_tuser;
              base_nxt  = 15'({10'd0, in_tdata[12:8]} * CANNED_DIV);
              val_nxt   = in_tdata[27:13];
              state_nxt = S_MOD;
            end
          end else begin
            acc_nxt   = acc_upd;
            chars_nxt = chars_upd;
          end
        end
      end
      S_MOD: begin
        quot_nxt  = recip_prod[2*HASH_W-1:HASH_W];
        state_nxt = S_REM;
      end
      S_REM: begin
        rem_nxt   = hash_r - quot_mul;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        if (rem_r >= TS_W) begin
          idx_nxt = AW'(rem_r - TS_W);
        end else begin
          idx_nxt = AW'(rem_r);
        end
        probe_cnt_nxt = '0;
        state_nxt     = S_READ;
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt     = S_DONE;
        res_value_nxt = '0;
        unique case (mode_r)
          MODE_STORE: begin
            if (slot_empty) begin
              mem_we         = 1'b1;
              res_status_nxt = ST_STORED;
            end else begin
              state_nxt = S_READ;
            end
          end
          MODE_USER: begin
            if (slot_empty) begin
              res_status_nxt = ST_NOT_FOUND;
            end else if (hash_hit) begin
              res_status_nxt = ST_FOUND;
              res_value_nxt  = rd_val;
            end else begin
              state_nxt = S_READ;
            end
          end
          MODE_CANNED: begin
            if (slot_empty) begin
              res_status_nxt = ST_MISSING;
            end else if (hash_hit && type_hit) begin
              res_status_nxt = ST_FOUND;
              res_value_nxt  = val_diff;
            end else begin
              state_nxt = S_READ;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
        if (state_nxt == S_READ) begin
          probe_cnt_nxt = probe_inc;
          idx_nxt       = (idx_inc == TS) ? '0 : idx_inc[AW-1:0];
          if (probe_inc == TS) begin
            res_status_nxt = ST_OVERFLOW;
            state_nxt      = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      acc_r       <= '0;
      chars_r     <= MAX_CHARS;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      chars_r     <= chars_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hash_r       <= hash_nxt;
    mode_r       <= mode_nxt;
    base_r       <= base_nxt;
    val_r        <= val_nxt;
    quot_r       <= quot_nxt;
    rem_r        <= rem_nxt;
    probe_cnt_r  <= probe_cnt_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_r] <= mem_wd;
    end
    rd_data_r <= mem[idx_r];
  end

endmodule

// File: sv/hwt_checker.sv
// Port-level assertions for the hashed word table, bound to the top level.
module hwt_checker
  import hwt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [2:0]  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_STORED) || (out_tuser == ST_FOUND) ||
                   (out_tuser == ST_NOT_FOUND) || (out_tuser == ST_OVERFLOW) ||
                   (out_tuser == ST_MISSING))
    else $error("status code out of range");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_FOUND) |-> out_tdata == 16'd0)
    else $error("nonzero value without a hit");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast && !out_tvalid |=> !out_tvalid)
    else $error("result without a last byte");

endmodule

bind hashed_word_table_core hwt_checker u_hwt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
